[rtl/rhsv_pkg.sv]
package rhsv_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int CH_W       = 8;
	// Divider operands must hold six times the largest channel value.
	localparam int OPND_W     = CH_W + 3;
	localparam int Q_W        = FRAC_BITS + 1;
	// One stage for the integer quotient bit, then one per fraction bit.
	localparam int DIV_STAGES = FRAC_BITS + 1;

	localparam logic [Q_W-1:0] HUE_GREY = Q_W'(1) << (FRAC_BITS - 1);

	// Sector base, chosen by which channel is the minimum.
	localparam logic [2:0] BASE_RED_MIN   = 3'd3;
	localparam logic [2:0] BASE_GREEN_MIN = 3'd5;
	localparam logic [2:0] BASE_BLUE_MIN  = 3'd1;

	typedef struct packed {
		logic            grey;
		logic [CH_W-1:0] value;
	} tag_t;

	typedef struct packed {
		logic              qbit;
		logic [OPND_W-1:0] rem;
	} step_t;

	// One restoring division step. The partial remainder is below twice the divisor.
	function automatic step_t div_step(input logic [OPND_W:0] part,
			input logic [OPND_W-1:0] den);
		step_t res;
		if (part >= {1'b0, den}) begin
			res.qbit = 1'b1;
			res.rem  = OPND_W'(part - {1'b0, den});
		end else begin
			res.qbit = 1'b0;
			res.rem  = part[OPND_W-1:0];
		end
		return res;
	endfunction

endpackage

[rtl/rhsv_front.sv]
module rhsv_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_in,
	input  logic [rhsv_pkg::CH_W-1:0]     red,
	input  logic [rhsv_pkg::CH_W-1:0]     green,
	input  logic [rhsv_pkg::CH_W-1:0]     blue,
	output logic                          vld_out,
	output logic [rhsv_pkg::OPND_W-1:0]   hue_num,
	output logic [rhsv_pkg::OPND_W-1:0]   hue_den,
	output logic [rhsv_pkg::OPND_W-1:0]   sat_num,
	output logic [rhsv_pkg::OPND_W-1:0]   sat_den,
	output rhsv_pkg::tag_t                tag
);

	logic                      vld_s1;
	logic [rhsv_pkg::CH_W-1:0] r_s1, g_s1, b_s1, hi_s1, lo_s1;
	logic [rhsv_pkg::CH_W-1:0] hi_in, lo_in, mx_rg, mn_rg;

	logic                        vld_s2;
	logic [rhsv_pkg::OPND_W-1:0] hue_num_s2, hue_den_s2, sat_num_s2, sat_den_s2;
	rhsv_pkg::tag_t              tag_s2;

	logic [rhsv_pkg::CH_W-1:0]   d;
	logic [2:0]                  base;
	logic signed [rhsv_pkg::CH_W:0]   f;
	logic [rhsv_pkg::OPND_W-1:0] d_ext, base_mul;
	logic signed [rhsv_pkg::OPND_W:0] num_full;

	assign mx_rg = (red > green) ? red : green;
	assign hi_in = (mx_rg > blue) ? mx_rg : blue;
	assign mn_rg = (red < green) ? red : green;
	assign lo_in = (mn_rg < blue) ? mn_rg : blue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		r_s1  <= red;
		g_s1  <= green;
		b_s1  <= blue;
		hi_s1 <= hi_in;
		lo_s1 <= lo_in;
	end

	assign d     = hi_s1 - lo_s1;
	assign d_ext = rhsv_pkg::OPND_W'(d);

	// Ties for the minimum go to red first, then green.
	always_comb begin
		if (r_s1 == lo_s1) begin
			base = rhsv_pkg::BASE_RED_MIN;
			f    = $signed({1'b0, g_s1}) - $signed({1'b0, b_s1});
		end else if (g_s1 == lo_s1) begin
			base = rhsv_pkg::BASE_GREEN_MIN;
			f    = $signed({1'b0, b_s1}) - $signed({1'b0, r_s1});
		end else begin
			base = rhsv_pkg::BASE_BLUE_MIN;
			f    = $signed({1'b0, r_s1}) - $signed({1'b0, g_s1});
		end
	end

	assign base_mul = rhsv_pkg::OPND_W'(base) * d_ext;
	// The hue numerator never goes below zero, so the low bits are the value.
	assign num_full = $signed({1'b0, base_mul})
		- $signed({{(rhsv_pkg::OPND_W - rhsv_pkg::CH_W){f[rhsv_pkg::CH_W]}}, f});

	always_ff @(posedge clk) begin
		hue_num_s2   <= num_full[rhsv_pkg::OPND_W-1:0];
		hue_den_s2   <= (d_ext << 2) + (d_ext << 1);
		sat_num_s2   <= d_ext;
		sat_den_s2   <= rhsv_pkg::OPND_W'(hi_s1);
		tag_s2.grey  <= (d == '0);
		tag_s2.value <= hi_s1;
	end

	assign vld_out = vld_s2;
	assign hue_num = hue_num_s2;
	assign hue_den = hue_den_s2;
	assign sat_num = sat_num_s2;
	assign sat_den = sat_den_s2;
	assign tag     = tag_s2;

endmodule

[rtl/rhsv_div_pipe.sv]
module rhsv_div_pipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vld_in,
	input  logic [rhsv_pkg::OPND_W-1:0]  hue_num,
	input  logic [rhsv_pkg::OPND_W-1:0]  hue_den,
	input  logic [rhsv_pkg::OPND_W-1:0]  sat_num,
	input  logic [rhsv_pkg::OPND_W-1:0]  sat_den,
	input  rhsv_pkg::tag_t               tag_in,
	output logic                         vld_out,
	output logic [rhsv_pkg::Q_W-1:0]     hue_quot,
	output logic [rhsv_pkg::Q_W-1:0]     sat_quot,
	output rhsv_pkg::tag_t               tag_out
);

	localparam int N = rhsv_pkg::DIV_STAGES;

	logic                        vld_s     [N];
	logic [rhsv_pkg::OPND_W-1:0] hue_rem_s [N];
	logic [rhsv_pkg::OPND_W-1:0] hue_den_s [N];
	logic [rhsv_pkg::Q_W-1:0]    hue_q_s   [N];
	logic [rhsv_pkg::OPND_W-1:0] sat_rem_s [N];
	logic [rhsv_pkg::OPND_W-1:0] sat_den_s [N];
	logic [rhsv_pkg::Q_W-1:0]    sat_q_s   [N];
	rhsv_pkg::tag_t              tag_s     [N];

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_stage
			rhsv_pkg::step_t hue_st, sat_st;

			if (i == 0) begin : g_first
				// Numerators never exceed their divisors, so one step yields the integer bit.
				assign hue_st = rhsv_pkg::div_step({1'b0, hue_num}, hue_den);
				assign sat_st = rhsv_pkg::div_step({1'b0, sat_num}, sat_den);

				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_s[i] <= 1'b0;
					end else begin
						vld_s[i] <= vld_in;
					end
				end

				always_ff @(posedge clk) begin
					hue_rem_s[i] <= hue_st.rem;
					hue_den_s[i] <= hue_den;
					hue_q_s[i]   <= rhsv_pkg::Q_W'(hue_st.qbit);
					sat_rem_s[i] <= sat_st.rem;
					sat_den_s[i] <= sat_den;
					sat_q_s[i]   <= rhsv_pkg::Q_W'(sat_st.qbit);
					tag_s[i]     <= tag_in;
				end
			end else begin : g_next
				assign hue_st = rhsv_pkg::div_step({hue_rem_s[i-1], 1'b0}, hue_den_s[i-1]);
				assign sat_st = rhsv_pkg::div_step({sat_rem_s[i-1], 1'b0}, sat_den_s[i-1]);

				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_s[i] <= 1'b0;
					end else begin
						vld_s[i] <= vld_s[i-1];
					end
				end

				always_ff @(posedge clk) begin
					hue_rem_s[i] <= hue_st.rem;
					hue_den_s[i] <= hue_den_s[i-1];
					hue_q_s[i]   <= {hue_q_s[i-1][rhsv_pkg::Q_W-2:0], hue_st.qbit};
					sat_rem_s[i] <= sat_st.rem;
					sat_den_s[i] <= sat_den_s[i-1];
					sat_q_s[i]   <= {sat_q_s[i-1][rhsv_pkg::Q_W-2:0], sat_st.qbit};
					tag_s[i]     <= tag_s[i-1];
				end
			end
		end
	endgenerate

	assign vld_out  = vld_s[N-1];
	assign hue_quot = hue_q_s[N-1];
	assign sat_quot = sat_q_s[N-1];
	assign tag_out  = tag_s[N-1];

endmodule

[rtl/rgb_to_hsv_converter_top.sv]
// RGB to HSV pixel converter, fully pipelined.
// Input: drive red, green and blue with start high; a transfer happens at each
// rising edge where start is high and busy is low. busy is held low, so one
// pixel can be transferred on every clock.
// Output: done is high with hue_frac, sat_frac and value_level valid in
// that same cycle; the receiver must take the transfer.
// Throughput is one pixel per clock.
// The pipeline is two input stages (max/min, then sector and operands),
// a 17-stage restoring divider that makes one quotient bit per stage for hue
// and saturation side by side, and the output register.
// Grey pixels bypass the divider result: hue is one half turn, saturation zero.
// Reset clears all valid bits, so no result appears until a new pixel arrives.
module rgb_to_hsv_converter_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [rhsv_pkg::CH_W-1:0]  red,
	input  logic [rhsv_pkg::CH_W-1:0]  green,
	input  logic [rhsv_pkg::CH_W-1:0]  blue,
	output logic                       done,
	output logic [rhsv_pkg::Q_W-1:0]   hue_frac,
	output logic [rhsv_pkg::Q_W-1:0]   sat_frac,
	output logic [rhsv_pkg::CH_W-1:0]  value_level
);

	logic                        accept;
	logic                        fr_vld;
	logic [rhsv_pkg::OPND_W-1:0] fr_hue_num, fr_hue_den, fr_sat_num, fr_sat_den;
	rhsv_pkg::tag_t              fr_tag;

	logic                        dv_vld;
	logic [rhsv_pkg::Q_W-1:0]    dv_hue, dv_sat;
	rhsv_pkg::tag_t              dv_tag;

	logic                        done_q;
	logic [rhsv_pkg::Q_W-1:0]    hue_q, sat_q;
	logic [rhsv_pkg::CH_W-1:0]   value_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	rhsv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (accept),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.vld_out (fr_vld),
		.hue_num (fr_hue_num),
		.hue_den (fr_hue_den),
		.sat_num (fr_sat_num),
		.sat_den (fr_sat_den),
		.tag     (fr_tag)
	);

	rhsv_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (fr_vld),
		.hue_num  (fr_hue_num),
		.hue_den  (fr_hue_den),
		.sat_num  (fr_sat_num),
		.sat_den  (fr_sat_den),
		.tag_in   (fr_tag),
		.vld_out  (dv_vld),
		.hue_quot (dv_hue),
		.sat_quot (dv_sat),
		.tag_out  (dv_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld;
		end
	end

	// A grey pixel divides the hue by zero in the divider, so its quotients are replaced here.
	always_ff @(posedge clk) begin
		hue_q   <= dv_tag.grey ? rhsv_pkg::HUE_GREY : dv_hue;
		sat_q   <= dv_tag.grey ? '0 : dv_sat;
		value_q <= dv_tag.value;
	end

	assign done        = done_q;
	assign hue_frac    = hue_q;
	assign sat_frac    = sat_q;
	assign value_level = value_q;

endmodule
